FILE: hdl/tks_pkg.sv
`timescale 1ns / 1ps
package tks_pkg;

    localparam int KEEP_DEFAULT = 8;

    typedef struct packed {
        logic [15:0] pt;
        logic [15:0] eta;
        logic [15:0] phi;
        logic [15:0] kind;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

FILE: hdl/tks_in_if.sv
`timescale 1ns / 1ps
interface tks_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pt;
    logic [15:0] eta;
    logic [15:0] phi;
    logic [15:0] kind;
    logic        frame_end;

    modport source (output valid, pt, eta, phi, kind, frame_end, input ready);
    modport sink   (input valid, pt, eta, phi, kind, frame_end, output ready);
endinterface

FILE: hdl/tks_out_if.sv
`timescale 1ns / 1ps
interface tks_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pt_out;
    logic [15:0] eta_out;
    logic [15:0] phi_out;
    logic [15:0] kind_out;
    logic        rank_last;

    modport source (output valid, pt_out, eta_out, phi_out, kind_out, rank_last,
                    input ready);
    modport sink   (input valid, pt_out, eta_out, phi_out, kind_out, rank_last,
                    output ready);
endinterface

FILE: hdl/tks_store.sv
`timescale 1ns / 1ps
module tks_store #(
    parameter int KEEP = tks_pkg::KEEP_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic                        flush,
    input  tks_pkg::rec_t               rec,
    output tks_pkg::rec_t [KEEP-1:0]    inserted
);
    import tks_pkg::*;

    rec_t [KEEP-1:0] slot_reg;
    rec_t [KEEP-1:0] slot_next;
    rec_t [KEEP-1:0] above_rec;
    logic [KEEP-1:0] above_ge;
    logic [KEEP-1:0] ge;

    // slots stay sorted descending, so ge is a thermometer code
    always_comb
    begin
        above_rec[0] = '0;
        above_ge[0]  = 1'b0;
        for (int i = 0; i < KEEP; i++)
        begin
            ge[i] = (slot_reg[i].pt <= rec.pt);
        end
        for (int i = 1; i < KEEP; i++)
        begin
            above_rec[i] = slot_reg[i-1];
            above_ge[i]  = ge[i-1];
        end
        for (int i = 0; i < KEEP; i++)
        begin
            if (!ge[i])
            begin
                inserted[i] = slot_reg[i];
            end
            else if (above_ge[i])
            begin
                inserted[i] = above_rec[i];
            end
            else
            begin
                inserted[i] = rec;
            end
        end
    end

    always_comb
    begin
        slot_next = flush ? '0 : inserted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (take)
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

FILE: hdl/tks_drain.sv
`timescale 1ns / 1ps
module tks_drain #(
    parameter int KEEP = tks_pkg::KEEP_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  tks_pkg::rec_t [KEEP-1:0]    snap,
    output logic                        busy,
    tks_out_if.source                   ranked
);
    import tks_pkg::*;

    localparam int CW = $clog2(KEEP + 1);

    rec_t [KEEP-1:0] bank_reg;
    rec_t [KEEP-1:0] bank_next;
    logic [CW-1:0]   cnt_reg;
    logic            vld_reg;
    rec_t            beat_reg;
    logic            last_reg;
    logic            emit;

    assign busy      = (cnt_reg != '0);
    assign emit      = busy && (!vld_reg || ranked.ready);
    assign bank_next = bank_reg >> REC_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cnt_reg <= CW'(KEEP);
            end
            else if (emit)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (emit)
            begin
                vld_reg <= 1'b1;
            end
            else if (ranked.ready)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bank_reg <= snap;
        end
        else if (emit)
        begin
            bank_reg <= bank_next;
        end
        if (emit)
        begin
            beat_reg <= bank_reg[0];
            last_reg <= (cnt_reg == CW'(1));
        end
    end

    assign ranked.valid     = vld_reg;
    assign ranked.pt_out    = beat_reg.pt;
    assign ranked.eta_out   = beat_reg.eta;
    assign ranked.phi_out   = beat_reg.phi;
    assign ranked.kind_out  = beat_reg.kind;
    assign ranked.rank_last = last_reg;

endmodule

FILE: hdl/top_k_insertion_sorter.sv
`timescale 1ns / 1ps
// Output: an accepted frame_end loads the drain bank, which passes rank 0 to the output
//   register, then one ranked beat per cycle unless stalled, KEEP in all, the last with rank_last.
// Throughput: one record beat per cycle; a frame_end beat waits while the drain
//   bank still holds the previous frame's KEEP beats (set by the single output port).
// Reset (rst_n, async, active low): store slots cleared to zero, drain idle,
//   no output beat pending.
module top_k_insertion_sorter #(
    parameter int KEEP = tks_pkg::KEEP_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    tks_in_if.sink    records,
    tks_out_if.source ranked
);
    import tks_pkg::*;

    rec_t            rec;
    rec_t [KEEP-1:0] inserted;
    logic            fire;
    logic            flush;
    logic            busy;

    // A frame end can only hand its snapshot over when the drain bank is free.
    // Plain records never wait: the store takes one every cycle.
    assign records.ready = !(records.frame_end && busy);
    assign fire          = records.valid && records.ready;
    assign flush         = fire && records.frame_end;

    assign rec.pt   = records.pt;
    assign rec.eta  = records.eta;
    assign rec.phi  = records.phi;
    assign rec.kind = records.kind;

    // Sorted store: parallel compare against every slot, shift-down insert.
    // On a frame end the post-insert view goes to the drain and the store clears.
    tks_store #(
        .KEEP (KEEP)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (fire),
        .flush    (flush),
        .rec      (rec),
        .inserted (inserted)
    );

    // Drain bank plus output register: shifts out one ranked beat per cycle unless the output stalls.
    tks_drain #(
        .KEEP (KEEP)
    ) u_drain (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (flush),
        .snap   (inserted),
        .busy   (busy),
        .ranked (ranked)
    );

    // A snapshot never lands on a bank that is still draining.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        flush |-> !busy)
        else $error("frame end accepted while drain busy");

    // A frame end always starts a drain.
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        flush |=> busy)
        else $error("drain did not start after frame end");

    // Every ranked beat leaves from a busy drain or a held output register.
    a_beat_src: assert property (@(posedge clk) disable iff (!rst_n)
        (ranked.valid && !$past(ranked.valid)) |-> $past(busy))
        else $error("output beat without drain activity");

    generate
        if (KEEP > 1)
        begin : g_order
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                inserted[0].pt >= inserted[1].pt)
                else $error("store lost descending order");
        end
    endgenerate

endmodule

FILE: tb/top_k_insertion_sorter_tb.sv
`timescale 1ns / 1ps
// Checks the top-k insertion sorter beat by beat. A tracker keeps its own copy
// of the ranked store, updates it on every accepted record beat and, on a
// frame end, queues the KEEP ranked beats that the block must emit next.
module top_k_insertion_sorter_tb;
    import tks_pkg::*;

    localparam int KEEP = KEEP_DEFAULT;
    // Cycles with no beat accepted on either side before the run is called hung.
    // The longest honest quiet stretch is a sender gap or a receiver stall at
    // 57 percent idling.
    localparam int QUIET_LIMIT = 2000;

    // One ranked beat as the block should emit it.
    typedef struct {
        rec_t rec;
        logic last;
    } ranked_beat_t;

    // Holds the running top-k list of the current frame and the ranked beats
    // that are still owed by the block.
    class top_k_tracker;
        rec_t         slots[KEEP];
        ranked_beat_t ranked_due[$];
        int           mismatches;

        function new();
            clear_slots();
            mismatches = 0;
        endfunction

        function void clear_slots();
            int i;
            for (i = 0; i < KEEP; i++)
                slots[i] = '0;
        endfunction

        // Insert behind strictly larger pt, ahead of equal or smaller pt;
        // an empty slot holds pt 0, so a zero record fills it.
        function void take_record(rec_t r, logic frame_end);
            int pos;
            int i;
            ranked_beat_t b;
            pos = KEEP;
            for (i = 0; i < KEEP; i++)
            begin
                if (slots[i].pt <= r.pt)
                begin
                    pos = i;
                    break;
                end
            end
            if (pos < KEEP)
            begin
                for (i = KEEP - 1; i > pos; i--)
                    slots[i] = slots[i - 1];
                slots[pos] = r;
            end
            if (frame_end)
            begin
                for (i = 0; i < KEEP; i++)
                begin
                    b.rec  = slots[i];
                    b.last = (i == KEEP - 1);
                    ranked_due.push_back(b);
                end
                clear_slots();
            end
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            mismatches++;
            $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_ranked(rec_t got, logic last);
            ranked_beat_t want;
            if (ranked_due.size() == 0)
            begin
                report_mismatch("ranked beat with none outstanding, pt_out", got.pt, 0);
                return;
            end
            want = ranked_due.pop_front();
            if (got.pt !== want.rec.pt)
                report_mismatch("pt_out", got.pt, want.rec.pt);
            if (got.eta !== want.rec.eta)
                report_mismatch("eta_out", got.eta, want.rec.eta);
            if (got.phi !== want.rec.phi)
                report_mismatch("phi_out", got.phi, want.rec.phi);
            if (got.kind !== want.rec.kind)
                report_mismatch("kind_out", got.kind, want.rec.kind);
            if (last !== want.last)
                report_mismatch("rank_last", last, want.last);
        endtask
    endclass

    logic clk;
    logic rst_n;

    tks_in_if  rec_if ();
    tks_out_if rank_if ();

    top_k_insertion_sorter #(
        .KEEP(KEEP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .records(rec_if),
        .ranked(rank_if)
    );

    top_k_tracker tracker = new();

    // Idle rates in percent, changed per phase by the main sequence.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int quiet_cycles  = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls at the current rate; zero rate means always ready.
    always @(posedge clk)
        rank_if.ready <= ($urandom_range(99) >= sink_idle_pct);

    // Monitor: both channels sampled at the same edge. Everything it reads is
    // driven by nonblocking assignments, so it sees the pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rec_if.valid && rec_if.ready)
                tracker.take_record({rec_if.pt, rec_if.eta, rec_if.phi, rec_if.kind},
                                    rec_if.frame_end);
            if (rank_if.valid && rank_if.ready)
                tracker.check_ranked({rank_if.pt_out, rank_if.eta_out,
                                      rank_if.phi_out, rank_if.kind_out},
                                     rank_if.rank_last);
        end
    end

    // Watchdog: any accepted beat on either side counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rec_if.valid && rec_if.ready) || (rank_if.valid && rank_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic rec_t make_rec(logic [15:0] pt, logic [15:0] eta,
                                      logic [15:0] phi, logic [15:0] kind);
        rec_t r;
        r.pt   = pt;
        r.eta  = eta;
        r.phi  = phi;
        r.kind = kind;
        return r;
    endfunction

    // pt mix: plenty of near-equal small values for ties, plus both extremes.
    function automatic rec_t random_record();
        rec_t r;
        r.eta  = 16'($urandom);
        r.phi  = 16'($urandom);
        r.kind = 16'($urandom);
        case ($urandom_range(9))
            0:       r.pt = 16'h0000;
            1:       r.pt = 16'hFFFF;
            2, 3:    r.pt = 16'($urandom_range(8));
            default: r.pt = 16'($urandom);
        endcase
        return r;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the beat.
    // valid stays high straight into the next beat unless a gap is drawn.
    task automatic send_record(input rec_t r, input logic last_of_frame);
        if ($urandom_range(99) < src_idle_pct)
        begin
            rec_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        rec_if.valid     <= 1'b1;
        rec_if.pt        <= r.pt;
        rec_if.eta       <= r.eta;
        rec_if.phi       <= r.phi;
        rec_if.kind      <= r.kind;
        rec_if.frame_end <= last_of_frame;
        do
            @(posedge clk);
        while (!rec_if.ready);
    endtask

    // Hold off the sender until every owed ranked beat has come out. The first
    // edge lets the monitor log a frame end accepted at the current edge.
    task automatic wait_drained();
        rec_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.ranked_due.size() != 0);
    endtask

    // Whole frames of random length; mostly short, now and then past KEEP
    // so the store overflows and drops its lowest entries.
    task automatic random_frames(input int count);
        int sent;
        int len;
        int i;
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 10);
            for (i = 0; i < len; i++)
                send_record(random_record(), i == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        int i;
        rst_n            = 1'b0;
        rec_if.valid     = 1'b0;
        rec_if.pt        = '0;
        rec_if.eta       = '0;
        rec_if.phi       = '0;
        rec_if.kind      = '0;
        rec_if.frame_end = 1'b0;
        rank_if.ready    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on the sender side.
        // Lone frame end: one all-ones record, the other KEEP-1 ranks stay empty.
        send_record(make_rec(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
        // Frame of all-zero fields: zero record fills the first empty slot.
        send_record(make_rec(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1);
        // Ties on pt: newest record must come out first.
        for (i = 0; i < 4; i++)
            send_record(make_rec(16'd100, 16'(16'h1111 * i), 16'hA5A5, 16'(i)), i == 3);
        // pt zero with nonzero payload: each lands at rank 0, so they come out newest first.
        for (i = 0; i < 3; i++)
            send_record(make_rec(16'h0000, 16'h5A5A, 16'(16'hC3C3 + i),
                                 16'(16'h8000 + i)), i == 2);
        // Rising pt: each record goes to rank 0, the ninth pushes the smallest
        // out, and the closing zero record falls off the full store.
        for (i = 1; i <= 9; i++)
            send_record(make_rec(16'(16'd10 * i), 16'h7FFF, 16'h8000, 16'(i)), 1'b0);
        send_record(make_rec(16'h0000, 16'hDEAD, 16'hBEEF, 16'h0001), 1'b1);

        // Sender holds back until the directed frames have fully drained.
        wait_drained();

        // Phase 1: sender idles lightly, receiver stalls often.
        src_idle_pct  = 17;
        sink_idle_pct = 57;
        random_frames(125);

        // Phase 2: the other way round, with a full drain part way through.
        src_idle_pct  = 57;
        sink_idle_pct = 17;
        random_frames(60);
        wait_drained();
        random_frames(60);

        // Phase 3: back to back on both sides.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_frames(125);

        wait_drained();
        // Catch any stray beat the block might emit after the last frame.
        repeat (KEEP + 4) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
